FILE: rtl/core/elj_pkg.sv
// Shared types and constants for the escaped line joiner.
`timescale 1ns / 1ps

package elj_pkg;

  localparam int LINE_COUNT_BITS = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ESCAPE_CHAR    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTINUE_CHAR  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMMENT_CHAR   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNESC_ESCAPE   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNESC_CONTINUE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNESC_COMMENT  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNESC_REST     = 3'd6;

  localparam logic [7:0] RST_ESCAPE_CHAR   = 8'd92;
  localparam logic [7:0] RST_CONTINUE_CHAR = 8'd92;
  localparam logic [7:0] RST_COMMENT_CHAR  = 8'd35;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [3:0] {
    MODE_LINE_START = 4'd0,
    MODE_TEXT       = 4'd1,
    MODE_ESC        = 4'd2,
    MODE_CONT       = 4'd3,
    MODE_COMMENT    = 4'd4,
    MODE_DISC       = 4'd5,
    MODE_DISC_ESC   = 4'd6,
    MODE_DISC_CONT  = 4'd7,
    MODE_DISC_CR    = 4'd8,
    MODE_SKIP_LF    = 4'd9
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        line_end;
    logic [31:0] line_number;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_end;
  } res_t;

  typedef struct packed {
    logic        two;
    res_t        r0;
    res_t        r1;
    logic [31:0] line_number;
  } rec_t;

  typedef struct packed {
    logic [7:0] escape_char;
    logic [7:0] continue_char;
    logic [7:0] comment_char;
    logic       unesc_escape;
    logic       unesc_continue;
    logic       unesc_comment;
    logic       unesc_rest;
  } cfg_t;

  typedef struct packed {
    logic                      we;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

endpackage

FILE: rtl/core/elj_front.sv
// Front end: configuration registers and the per-byte line parser.
`timescale 1ns / 1ps

module elj_front #(
  parameter int LINE_COUNT_BITS = elj_pkg::LINE_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  elj_pkg::cfg_wr_t cfg_wr,
  input  logic             push,
  input  elj_pkg::in_t     item,
  output logic             full,
  input  logic             q_full,
  output logic             q_push,
  output elj_pkg::rec_t    q_rec
);

  typedef struct packed {
    elj_pkg::mode_t             mode;
    logic [7:0]                 prev;
    logic                       open;
    logic [LINE_COUNT_BITS-1:0] cnt;
    logic [1:0]                 nres;
    elj_pkg::res_t              r0;
    elj_pkg::res_t              r1;
  } st_t;

  elj_pkg::cfg_t              cfg;
  elj_pkg::mode_t             mode;
  logic [7:0]                 prev;
  logic                       line_open;
  logic [LINE_COUNT_BITS-1:0] line_cnt;
  st_t                        st_next;
  logic [63:0]                cnt_ext;
  logic                       accept;

  function automatic st_t emit(st_t s, logic [7:0] b, logic v, logic e);
    st_t           r;
    elj_pkg::res_t x;
    r = s;
    x.out_byte   = v ? b : 8'd0;
    x.byte_valid = v;
    x.line_end   = e;
    if (s.nres == 2'd0) begin
      r.r0   = x;
      r.nres = 2'd1;
    end else if (s.nres == 2'd1) begin
      r.r1   = x;
      r.nres = 2'd2;
    end
    return r;
  endfunction

  function automatic st_t end_line(st_t s);
    st_t r;
    r      = emit(s, 8'd0, 1'b0, 1'b1);
    r.open = 1'b0;
    r.mode = elj_pkg::MODE_LINE_START;
    return r;
  endfunction

  function automatic st_t text_byte(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (r.mode != elj_pkg::MODE_TEXT) begin
      r.cnt  = r.cnt + 1'b1;
      r.open = 1'b1;
    end
    r.mode = elj_pkg::MODE_TEXT;
    if (b == elj_pkg::CH_LF) begin
      r = end_line(r);
    end else if (c.escape_char != 8'd0 && b == c.escape_char) begin
      r.mode = elj_pkg::MODE_ESC;
    end else if (c.continue_char != 8'd0 && b == c.continue_char) begin
      r.mode = elj_pkg::MODE_CONT;
    end else if (c.comment_char != 8'd0 && b == c.comment_char) begin
      r.mode = elj_pkg::MODE_COMMENT;
      r.prev = b;
    end else begin
      r = emit(r, b, 1'b1, 1'b0);
    end
    return r;
  endfunction

  function automatic st_t comment_byte(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (b == elj_pkg::CH_LF) begin
      if (c.continue_char != 8'd0 && r.prev == c.continue_char) begin
        r.mode = elj_pkg::MODE_DISC;
      end else begin
        r = end_line(r);
      end
    end else begin
      r.prev = b;
    end
    return r;
  endfunction

  function automatic st_t disc_byte(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (b == elj_pkg::CH_LF) begin
      r.cnt = r.cnt + 1'b1;
      r     = end_line(r);
    end else if (c.escape_char != 8'd0 && b == c.escape_char) begin
      r.mode = elj_pkg::MODE_DISC_ESC;
    end else if (c.continue_char != 8'd0 && b == c.continue_char) begin
      r.mode = elj_pkg::MODE_DISC_CONT;
    end else if (b == elj_pkg::CH_CR) begin
      r.cnt  = r.cnt + 1'b1;
      r      = end_line(r);
      r.mode = elj_pkg::MODE_SKIP_LF;
    end
    return r;
  endfunction

  function automatic st_t join_lines(st_t s, logic [7:0] held, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (!c.unesc_continue) begin
      r = emit(r, held, 1'b1, 1'b0);
      r = emit(r, elj_pkg::CH_LF, 1'b1, 1'b0);
    end
    r.mode = elj_pkg::MODE_LINE_START;
    return r;
  endfunction

  function automatic st_t esc_byte(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t  r;
    logic drop;
    r    = s;
    drop = c.unesc_rest ||
           (c.unesc_comment && c.comment_char != 8'd0 && b == c.comment_char);
    if (b == elj_pkg::CH_LF && c.escape_char == c.continue_char) begin
      r = join_lines(r, c.escape_char, c);
    end else if (b != elj_pkg::CH_LF && b == c.escape_char && c.unesc_escape) begin
      r      = emit(r, b, 1'b1, 1'b0);
      r.mode = elj_pkg::MODE_TEXT;
    end else if (b == elj_pkg::CH_LF) begin
      if (drop) begin
        r = emit(r, 8'd0, 1'b0, 1'b1);
      end else begin
        r = emit(r, c.escape_char, 1'b1, 1'b1);
      end
      r.open = 1'b0;
      r.mode = elj_pkg::MODE_LINE_START;
    end else begin
      if (!drop) begin
        r = emit(r, c.escape_char, 1'b1, 1'b0);
      end
      r      = emit(r, b, 1'b1, 1'b0);
      r.mode = elj_pkg::MODE_TEXT;
    end
    return r;
  endfunction

  function automatic st_t cont_byte(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (b == elj_pkg::CH_LF) begin
      r = join_lines(r, c.continue_char, c);
    end else if (c.comment_char != 8'd0 && c.continue_char == c.comment_char) begin
      r.mode = elj_pkg::MODE_COMMENT;
      r      = comment_byte(r, b, c);
    end else begin
      r      = emit(r, c.continue_char, 1'b1, 1'b0);
      r.mode = elj_pkg::MODE_TEXT;
      r      = text_byte(r, b, c);
    end
    return r;
  endfunction

  function automatic st_t disc_tail(st_t s, logic [7:0] b, logic after_esc,
                                    elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (b == elj_pkg::CH_LF || b == elj_pkg::CH_CR) begin
      r.cnt = r.cnt + 1'b1;
      if (after_esc && c.escape_char != c.continue_char) begin
        r = end_line(r);
        if (b == elj_pkg::CH_CR) begin
          r.mode = elj_pkg::MODE_SKIP_LF;
        end
      end else begin
        r.mode = (b == elj_pkg::CH_CR) ? elj_pkg::MODE_DISC_CR : elj_pkg::MODE_DISC;
      end
    end else if (after_esc) begin
      r.mode = elj_pkg::MODE_DISC;
    end else begin
      r.mode = elj_pkg::MODE_DISC;
      r      = disc_byte(r, b, c);
    end
    return r;
  endfunction

  function automatic st_t feed(st_t s, logic [7:0] b, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    case (s.mode)
      elj_pkg::MODE_TEXT:      r = text_byte(r, b, c);
      elj_pkg::MODE_ESC:       r = esc_byte(r, b, c);
      elj_pkg::MODE_CONT:      r = cont_byte(r, b, c);
      elj_pkg::MODE_COMMENT:   r = comment_byte(r, b, c);
      elj_pkg::MODE_DISC:      r = disc_byte(r, b, c);
      elj_pkg::MODE_DISC_ESC:  r = disc_tail(r, b, 1'b1, c);
      elj_pkg::MODE_DISC_CONT: r = disc_tail(r, b, 1'b0, c);
      elj_pkg::MODE_DISC_CR: begin
        r.mode = elj_pkg::MODE_DISC;
        if (b != elj_pkg::CH_LF) begin
          r = disc_byte(r, b, c);
        end
      end
      elj_pkg::MODE_SKIP_LF: begin
        r.mode = elj_pkg::MODE_LINE_START;
        if (b != elj_pkg::CH_LF) begin
          r = text_byte(r, b, c);
        end
      end
      default: begin
        r.mode = elj_pkg::MODE_LINE_START;
        r      = text_byte(r, b, c);
      end
    endcase
    return r;
  endfunction

  function automatic st_t finish(st_t s, elj_pkg::cfg_t c);
    st_t r;
    r = s;
    if (s.mode == elj_pkg::MODE_ESC) begin
      r = emit(r, c.escape_char, 1'b1, 1'b1);
    end else if (s.mode == elj_pkg::MODE_CONT &&
                 !(c.comment_char != 8'd0 && c.continue_char == c.comment_char)) begin
      r = emit(r, c.continue_char, 1'b1, 1'b1);
    end else if (s.open ||
                 (s.mode >= elj_pkg::MODE_TEXT && s.mode <= elj_pkg::MODE_DISC_CR)) begin
      r = emit(r, 8'd0, 1'b0, 1'b1);
    end
    r.open = 1'b0;
    r.mode = elj_pkg::MODE_LINE_START;
    return r;
  endfunction

  always_comb begin
    st_t s;
    s.mode = mode;
    s.prev = prev;
    s.open = line_open;
    s.cnt  = line_cnt;
    s.nres = 2'd0;
    s.r0   = '0;
    s.r1   = '0;
    if (item.end_of_input) begin
      st_next = finish(s, cfg);
    end else begin
      st_next = feed(s, item.in_byte, cfg);
    end
  end

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign cnt_ext = 64'(st_next.cnt);

  assign q_push            = accept && (st_next.nres != 2'd0);
  assign q_rec.two         = st_next.nres[1];
  assign q_rec.r0          = st_next.r0;
  assign q_rec.r1          = st_next.r1;
  assign q_rec.line_number = cnt_ext[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= elj_pkg::MODE_LINE_START;
      prev      <= 8'd0;
      line_open <= 1'b0;
      line_cnt  <= '0;
    end else if (accept) begin
      mode      <= st_next.mode;
      prev      <= st_next.prev;
      line_open <= st_next.open;
      line_cnt  <= st_next.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_char    <= elj_pkg::RST_ESCAPE_CHAR;
      cfg.continue_char  <= elj_pkg::RST_CONTINUE_CHAR;
      cfg.comment_char   <= elj_pkg::RST_COMMENT_CHAR;
      cfg.unesc_escape   <= 1'b0;
      cfg.unesc_continue <= 1'b0;
      cfg.unesc_comment  <= 1'b0;
      cfg.unesc_rest     <= 1'b0;
    end else if (cfg_wr.we) begin
      case (cfg_wr.index)
        elj_pkg::REG_ESCAPE_CHAR:    cfg.escape_char    <= cfg_wr.data[7:0];
        elj_pkg::REG_CONTINUE_CHAR:  cfg.continue_char  <= cfg_wr.data[7:0];
        elj_pkg::REG_COMMENT_CHAR:   cfg.comment_char   <= cfg_wr.data[7:0];
        elj_pkg::REG_UNESC_ESCAPE:   cfg.unesc_escape   <= cfg_wr.data[0];
        elj_pkg::REG_UNESC_CONTINUE: cfg.unesc_continue <= cfg_wr.data[0];
        elj_pkg::REG_UNESC_COMMENT:  cfg.unesc_comment  <= cfg_wr.data[0];
        elj_pkg::REG_UNESC_REST:     cfg.unesc_rest     <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/elj_queue.sv
// Short queue of parsed step records between front and back end.
`timescale 1ns / 1ps

module elj_queue #(
  parameter int DEPTH = elj_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  elj_pkg::rec_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output elj_pkg::rec_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  elj_pkg::rec_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not advance on write");
`endif

endmodule

FILE: rtl/core/elj_back.sv
// Back end: splits step records into result transactions behind an output register.
`timescale 1ns / 1ps

module elj_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  elj_pkg::rec_t q_head,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output elj_pkg::out_t result
);

  logic out_valid;
  logic phase;
  logic load;
  logic take;

  assign load  = !out_valid || pop;
  assign take  = load && !q_empty;
  assign q_pop = take && (phase || !q_head.two);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (take) begin
        phase <= phase ? 1'b0 : q_head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.line_number <= q_head.line_number;
      if (phase) begin
        result.out_byte   <= q_head.r1.out_byte;
        result.byte_valid <= q_head.r1.byte_valid;
        result.line_end   <= q_head.r1.line_end;
        result.last       <= 1'b1;
      end else begin
        result.out_byte   <= q_head.r0.out_byte;
        result.byte_valid <= q_head.r0.byte_valid;
        result.line_end   <= q_head.r0.line_end;
        result.last       <= !q_head.two;
      end
    end
  end

endmodule

FILE: rtl/core/escaped_line_joiner.sv
// Top level of the escaped line joiner.
// An accepted byte's results pass through the record queue and then the output register.
// Throughput: one input byte per cycle unless full; a two-result byte gives two transactions.
// The per-byte parser is combinational; a four-entry record queue decouples the output.
// Reset (rst, synchronous): parser to line start, line count zero, queue and output empty,
// configuration registers to their default characters and cleared unescape flags.
`timescale 1ns / 1ps

module escaped_line_joiner #(
  parameter int LINE_COUNT_BITS = elj_pkg::LINE_COUNT_BITS,
  parameter int QUEUE_DEPTH     = elj_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  elj_pkg::in_t                       item,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output elj_pkg::out_t                      result,
  input  logic                               cfg_we,
  input  logic [elj_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [elj_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  elj_pkg::cfg_wr_t cfg_wr;
  logic             q_full;
  logic             q_push;
  elj_pkg::rec_t    q_rec;
  logic             q_empty;
  logic             q_pop;
  elj_pkg::rec_t    q_head;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  elj_front #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_rec)
  );

  elj_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_rec),
    .full  (q_full),
    .rd    (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  elj_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

FILE: tb/sv/escaped_line_joiner_test.sv
// Self-checking testbench for the escaped line joiner: directed rows, then random text per setting.
`timescale 1ns / 1ps

module escaped_line_joiner_test;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 90;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    elj_pkg::in_t  it;
    logic [1:0]    n_typed;
    elj_pkg::out_t r0;
    elj_pkg::out_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [elj_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [elj_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  elj_pkg::in_t  item = '0;
  logic full, empty;
  elj_pkg::out_t result;

  logic calm = 1'b0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   quiet = 0;
  int   settings_applied = 0;

  stim_row_t     directed_rows[$];
  stim_row_t     sent_rows[$];
  elj_pkg::out_t expected_lines[$];

  elj_pkg::cfg_t  regs = {elj_pkg::RST_ESCAPE_CHAR, elj_pkg::RST_CONTINUE_CHAR,
                          elj_pkg::RST_COMMENT_CHAR, 4'b0000};
  elj_pkg::mode_t mode = elj_pkg::MODE_LINE_START;
  logic [7:0]     last_comment_byte = 8'h00;
  logic           line_open = 1'b0;
  logic [31:0]    line_count = '0;
  elj_pkg::out_t  step_buf[0:1];
  int             step_n = 0;

  escaped_line_joiner u_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full), .empty(empty),
    .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void put_result(logic [7:0] b, logic v, logic e);
    elj_pkg::out_t r;
    if (step_n >= 2) return;
    r = '0;
    r.out_byte = v ? b : 8'h00;
    r.byte_valid = v;
    r.line_end = e;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void bump_line();
    line_count = line_count + 32'd1;
  endfunction

  function automatic void close_line();
    put_result(8'h00, 1'b0, 1'b1);
    line_open = 1'b0;
    mode = elj_pkg::MODE_LINE_START;
  endfunction

  function automatic void take_text(logic [7:0] b);
    if (mode != elj_pkg::MODE_TEXT) begin
      bump_line();
      line_open = 1'b1;
    end
    mode = elj_pkg::MODE_TEXT;
    if (b == elj_pkg::CH_LF) begin
      close_line();
    end else if (regs.escape_char != 0 && b == regs.escape_char) begin
      mode = elj_pkg::MODE_ESC;
    end else if (regs.continue_char != 0 && b == regs.continue_char) begin
      mode = elj_pkg::MODE_CONT;
    end else if (regs.comment_char != 0 && b == regs.comment_char) begin
      mode = elj_pkg::MODE_COMMENT;
      last_comment_byte = b;
    end else begin
      put_result(b, 1'b1, 1'b0);
    end
  endfunction

  function automatic void take_comment(logic [7:0] b);
    if (b == elj_pkg::CH_LF) begin
      if (regs.continue_char != 0 && last_comment_byte == regs.continue_char) begin
        mode = elj_pkg::MODE_DISC;
      end else begin
        close_line();
      end
    end else begin
      last_comment_byte = b;
    end
  endfunction

  function automatic void take_discard(logic [7:0] b);
    if (b == elj_pkg::CH_LF) begin
      bump_line();
      close_line();
    end else if (regs.escape_char != 0 && b == regs.escape_char) begin
      mode = elj_pkg::MODE_DISC_ESC;
    end else if (regs.continue_char != 0 && b == regs.continue_char) begin
      mode = elj_pkg::MODE_DISC_CONT;
    end else if (b == elj_pkg::CH_CR) begin
      bump_line();
      close_line();
      mode = elj_pkg::MODE_SKIP_LF;
    end
  endfunction

  function automatic void join_lines(logic [7:0] held);
    if (!regs.unesc_continue) begin
      put_result(held, 1'b1, 1'b0);
      put_result(elj_pkg::CH_LF, 1'b1, 1'b0);
    end
    mode = elj_pkg::MODE_LINE_START;
  endfunction

  function automatic void take_escaped(logic [7:0] b);
    logic drop;
    if (b == elj_pkg::CH_LF && regs.escape_char == regs.continue_char) begin
      join_lines(regs.escape_char);
      return;
    end
    if (b != elj_pkg::CH_LF && b == regs.escape_char && regs.unesc_escape) begin
      put_result(b, 1'b1, 1'b0);
      mode = elj_pkg::MODE_TEXT;
      return;
    end
    drop = regs.unesc_rest ||
           (regs.unesc_comment && regs.comment_char != 0 && b == regs.comment_char);
    if (b == elj_pkg::CH_LF) begin
      if (drop) put_result(8'h00, 1'b0, 1'b1);
      else put_result(regs.escape_char, 1'b1, 1'b1);
      line_open = 1'b0;
      mode = elj_pkg::MODE_LINE_START;
      return;
    end
    if (!drop) put_result(regs.escape_char, 1'b1, 1'b0);
    put_result(b, 1'b1, 1'b0);
    mode = elj_pkg::MODE_TEXT;
  endfunction

  function automatic void take_continued(logic [7:0] b);
    if (b == elj_pkg::CH_LF) begin
      join_lines(regs.continue_char);
    end else if (regs.comment_char != 0 && regs.continue_char == regs.comment_char) begin
      mode = elj_pkg::MODE_COMMENT;
      take_comment(b);
    end else begin
      put_result(regs.continue_char, 1'b1, 1'b0);
      mode = elj_pkg::MODE_TEXT;
      take_text(b);
    end
  endfunction

  function automatic void take_discard_tail(logic [7:0] b, logic after_esc);
    if (b == elj_pkg::CH_LF || b == elj_pkg::CH_CR) begin
      bump_line();
      if (after_esc && regs.escape_char != regs.continue_char) begin
        close_line();
        if (b == elj_pkg::CH_CR) mode = elj_pkg::MODE_SKIP_LF;
      end else begin
        mode = (b == elj_pkg::CH_CR) ? elj_pkg::MODE_DISC_CR : elj_pkg::MODE_DISC;
      end
    end else if (after_esc) begin
      mode = elj_pkg::MODE_DISC;
    end else begin
      mode = elj_pkg::MODE_DISC;
      take_discard(b);
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    case (mode)
      elj_pkg::MODE_TEXT:      take_text(b);
      elj_pkg::MODE_ESC:       take_escaped(b);
      elj_pkg::MODE_CONT:      take_continued(b);
      elj_pkg::MODE_COMMENT:   take_comment(b);
      elj_pkg::MODE_DISC:      take_discard(b);
      elj_pkg::MODE_DISC_ESC:  take_discard_tail(b, 1'b1);
      elj_pkg::MODE_DISC_CONT: take_discard_tail(b, 1'b0);
      elj_pkg::MODE_DISC_CR: begin
        mode = elj_pkg::MODE_DISC;
        if (b != elj_pkg::CH_LF) take_discard(b);
      end
      elj_pkg::MODE_SKIP_LF: begin
        mode = elj_pkg::MODE_LINE_START;
        if (b != elj_pkg::CH_LF) take_text(b);
      end
      default: begin
        mode = elj_pkg::MODE_LINE_START;
        take_text(b);
      end
    endcase
  endfunction

  function automatic void flush_line();
    if (mode == elj_pkg::MODE_ESC) begin
      put_result(regs.escape_char, 1'b1, 1'b1);
    end else if (mode == elj_pkg::MODE_CONT &&
                 !(regs.comment_char != 0 && regs.continue_char == regs.comment_char)) begin
      put_result(regs.continue_char, 1'b1, 1'b1);
    end else if (line_open ||
                 (mode >= elj_pkg::MODE_TEXT && mode <= elj_pkg::MODE_DISC_CR)) begin
      put_result(8'h00, 1'b0, 1'b1);
    end
    line_open = 1'b0;
    mode = elj_pkg::MODE_LINE_START;
  endfunction

  function automatic void predict_lines(elj_pkg::in_t it);
    elj_pkg::out_t r;
    step_n = 0;
    if (it.end_of_input) flush_line();
    else take_byte(it.in_byte);
    for (int k = 0; k < step_n; k++) begin
      r = step_buf[k];
      r.line_number = line_count;
      r.last = (k == step_n - 1);
      step_buf[k] = r;
    end
  endfunction

  function automatic elj_pkg::out_t line_result(logic [7:0] b, logic v, logic e,
                                                logic [31:0] n, logic l);
    return {b, v, e, n, l};
  endfunction

  function automatic stim_row_t raw_row(logic [7:0] b, logic eoi);
    stim_row_t row;
    row = '0;
    row.it.in_byte = b;
    row.it.end_of_input = eoi;
    return row;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return elj_pkg::CH_LF;
      2:       return CH_BACKSLASH;
      3:       return CH_HASH;
      4:       return elj_pkg::CH_CR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_next();
    case ($urandom_range(5))
      0:       return elj_pkg::CH_LF;
      1:       return elj_pkg::CH_CR;
      2:       return regs.escape_char;
      3:       return regs.continue_char;
      4:       return regs.comment_char;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_row(input logic [7:0] b, input logic eoi, input logic [1:0] n,
                         input elj_pkg::out_t r0, input elj_pkg::out_t r1);
    stim_row_t row;
    row = raw_row(b, eoi);
    row.n_typed = n;
    row.r0 = r0;
    row.r1 = r1;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input stim_row_t row);
    while (!calm && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= row.it;
    sent_rows.push_back(row);
    items_sent++;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_token();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6: send_item(raw_row(8'($urandom), 1'b0));
      7, 8: begin
        send_item(raw_row(regs.escape_char, 1'b0));
        send_item(raw_row(pick_next(), 1'b0));
      end
      9, 10: begin
        send_item(raw_row(regs.continue_char, 1'b0));
        send_item(raw_row(elj_pkg::CH_LF, 1'b0));
      end
      11:     send_item(raw_row(regs.comment_char, 1'b0));
      12, 13: send_item(raw_row(elj_pkg::CH_LF, 1'b0));
      14:     send_item(raw_row(elj_pkg::CH_CR, 1'b0));
      15: begin
        send_item(raw_row(elj_pkg::CH_CR, 1'b0));
        send_item(raw_row(elj_pkg::CH_LF, 1'b0));
      end
      16: send_item(raw_row(8'($urandom), 1'b1));
      17: send_item(raw_row(regs.escape_char, 1'b0));
      18: send_item(raw_row(regs.continue_char, 1'b0));
      default: begin
        send_item(raw_row(regs.comment_char, 1'b0));
        send_item(raw_row(8'($urandom), 1'b0));
        send_item(raw_row(regs.continue_char, 1'b0));
        send_item(raw_row(elj_pkg::CH_LF, 1'b0));
        send_item(raw_row(pick_next(), 1'b0));
      end
    endcase
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(negedge clk);
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [elj_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [elj_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input elj_pkg::cfg_t s);
    logic [6:0] junk;
    wait_idle();
    junk = 7'($urandom);
    write_reg(elj_pkg::REG_ESCAPE_CHAR, s.escape_char);
    write_reg(elj_pkg::REG_CONTINUE_CHAR, s.continue_char);
    write_reg(elj_pkg::REG_COMMENT_CHAR, s.comment_char);
    write_reg(elj_pkg::REG_UNESC_ESCAPE, {junk, s.unesc_escape});
    write_reg(elj_pkg::REG_UNESC_CONTINUE, {~junk, s.unesc_continue});
    write_reg(elj_pkg::REG_UNESC_COMMENT, {junk, s.unesc_comment});
    write_reg(elj_pkg::REG_UNESC_REST, {~junk, s.unesc_rest});
    cfg_we <= 1'b0;
    regs = s;
    settings_applied++;
  endtask

  always @(posedge clk) pop <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk) begin : monitor
    stim_row_t     row;
    elj_pkg::out_t got;
    elj_pkg::out_t want;
    if (!rst) begin
      quiet = quiet + 1;
      if (push && !full) begin
        quiet = 0;
        row = sent_rows.pop_front();
        predict_lines(item);
        if (row.n_typed != 0) begin
          expected_lines.push_back(row.r0);
          if (row.n_typed == 2) expected_lines.push_back(row.r1);
        end else begin
          for (int k = 0; k < step_n; k++) expected_lines.push_back(step_buf[k]);
        end
      end
      if (pop && !empty) begin
        quiet = 0;
        results_seen++;
        got = result;
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, got byte %02h valid %0b",
                   $time, got.out_byte, got.byte_valid);
          $display("%0t:   end %0b line %0d last %0b", $time, got.line_end,
                   got.line_number, got.last);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
              got.line_end !== want.line_end || got.line_number !== want.line_number ||
              got.last !== want.last) begin
            $display("%0t: mismatch: expected byte %02h valid %0b end %0b line %0d last %0b",
                     $time, want.out_byte, want.byte_valid, want.line_end,
                     want.line_number, want.last);
            $display("%0t:   actual   byte %02h valid %0b end %0b line %0d last %0b",
                     $time, got.out_byte, got.byte_valid, got.line_end,
                     got.line_number, got.last);
            mismatches++;
          end
        end
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 expected_lines.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    elj_pkg::cfg_t s;
    int phase_start;
    add_row(8'h41, 1'b0, 2'd1, line_result(8'h41, 1'b1, 1'b0, 32'd1, 1'b1), '0);
    add_row(8'hFF, 1'b0, 2'd1, line_result(8'hFF, 1'b1, 1'b0, 32'd1, 1'b1), '0);
    add_row(8'h00, 1'b0, 2'd1, line_result(8'h00, 1'b1, 1'b0, 32'd1, 1'b1), '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(elj_pkg::CH_LF, 1'b0, 2'd2, line_result(CH_BACKSLASH, 1'b1, 1'b0, 32'd1, 1'b0),
            line_result(elj_pkg::CH_LF, 1'b1, 1'b0, 32'd1, 1'b1));
    add_row(8'h42, 1'b0, 2'd0, '0, '0);
    add_row(CH_HASH, 1'b0, 2'd0, '0, '0);
    add_row(8'h78, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(elj_pkg::CH_LF, 1'b0, 2'd0, '0, '0);
    add_row(8'h79, 1'b0, 2'd0, '0, '0);
    add_row(elj_pkg::CH_CR, 1'b0, 2'd0, '0, '0);
    add_row(elj_pkg::CH_LF, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(8'h71, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(CH_HASH, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(8'h5A, 1'b1, 2'd0, '0, '0);
    add_row(8'hA5, 1'b1, 2'd0, '0, '0);
    add_row(8'h43, 1'b0, 2'd0, '0, '0);
    add_row(8'hFF, 1'b1, 2'd0, '0, '0);
    add_row(elj_pkg::CH_LF, 1'b0, 2'd0, '0, '0);
    add_row(CH_BACKSLASH, 1'b0, 2'd0, '0, '0);
    add_row(elj_pkg::CH_LF, 1'b0, 2'd0, '0, '0);
    add_row(8'h00, 1'b1, 2'd0, '0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = {elj_pkg::RST_ESCAPE_CHAR, elj_pkg::RST_CONTINUE_CHAR,
                elj_pkg::RST_COMMENT_CHAR, 4'b0000};
        1: s = {CH_BACKSLASH, CH_BACKSLASH, CH_HASH, 4'b1111};
        2: s = {CH_BACKSLASH, CH_SLASH, CH_HASH, 4'b0100};
        3: s = {CH_BACKSLASH, CH_SLASH, CH_HASH, 4'b1010};
        4: s = {CH_BACKSLASH, CH_HASH, CH_HASH, 4'b0101};
        5: s = {elj_pkg::CH_LF, elj_pkg::CH_LF, elj_pkg::CH_LF, 4'b1111};
        6: s = {8'h00, 8'h00, 8'h00, 4'b0000};
        7: s = {8'hFF, 8'hFF, 8'hFF, 4'b1001};
        default: begin
          s.escape_char = pick_char();
          s.continue_char = ($urandom_range(1) == 0) ? s.escape_char : pick_char();
          s.comment_char = pick_char();
          {s.unesc_escape, s.unesc_continue, s.unesc_comment, s.unesc_rest} = 4'($urandom);
        end
      endcase
      apply_setting(s);
      calm <= (p == 4);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_token();
    end

    wait_idle();
    @(negedge clk);
    $display("Sent %0d bytes and end marks under %0d register settings", items_sent,
             settings_applied);
    $display("Compared %0d line transactions, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: escaped_line_joiner.f
rtl/core/elj_pkg.sv
rtl/core/elj_front.sv
rtl/core/elj_queue.sv
rtl/core/elj_back.sv
rtl/core/escaped_line_joiner.sv
tb/sv/escaped_line_joiner_test.sv
